// ===== hdl/pksu_pkg.sv =====
// shared types, constants and helpers for the panel key and encoder scanner
package pksu_pkg;

	localparam int KEY_W     = 16;
	localparam int POS_W     = 8;
	localparam int REQ_W     = 2;
	localparam int CODE_W    = 5;
	localparam int DELTA_W   = 16;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 16;

	// number of key lines scanned by the priority encoder, never above KEY_W
	localparam int KEY_LINES  = 16;
	localparam int SCAN_LINES = (KEY_LINES < KEY_W) ? KEY_LINES : KEY_W;

	localparam int SUM_LIMIT = 32767;

	localparam logic [KEY_W-1:0] IDLE_PATTERN_RST = 16'hFFFF;
	localparam logic [POS_W-1:0] WRAP_HIGH_RST    = 8'd200;
	localparam logic [POS_W-1:0] WRAP_LOW_RST     = 8'd50;

	typedef enum logic [REQ_W-1:0] {
		REQ_TICK     = 2'd0,
		REQ_READ_KEY = 2'd1,
		REQ_READ_A   = 2'd2,
		REQ_READ_B   = 2'd3
	} req_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_IDLE_PATTERN = 2'd0,
		CFG_WRAP_HIGH    = 2'd1,
		CFG_WRAP_LOW     = 2'd2
	} cfg_reg_t;

	typedef enum logic [1:0] {
		PHASE_IDLE    = 2'd0,
		PHASE_CONFIRM = 2'd1,
		PHASE_HELD    = 2'd2
	} key_phase_t;

	typedef struct packed {
		logic sample;
		logic read;
	} key_ctl_t;

	typedef struct packed {
		logic tick;
		logic clear;
	} enc_ctl_t;

	// index plus one of the lowest low line, zero if none is low
	function automatic logic [CODE_W-1:0] low_line_code(input logic [KEY_W-1:0] pat);
		logic [CODE_W-1:0] code;
		code = '0;
		for (int i = SCAN_LINES - 1; i >= 0; i--) begin
			if (!pat[i]) begin
				code = CODE_W'(i + 1);
			end
		end
		return code;
	endfunction

endpackage

// ===== hdl/pksu_key.sv =====
// key debounce state machine with latched key code
module pksu_key (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pksu_pkg::key_ctl_t            ctl,
	input  logic [pksu_pkg::KEY_W-1:0]    keys,
	input  logic [pksu_pkg::KEY_W-1:0]    idle_pattern,
	output logic [pksu_pkg::CODE_W-1:0]   code
);

	pksu_pkg::key_phase_t              phase_q, phase_nxt;
	logic [pksu_pkg::KEY_W-1:0]        cand_q, cand_nxt;
	logic [pksu_pkg::CODE_W-1:0]       latched_q, latched_nxt;
	logic                              ready_q, ready_nxt;
	logic [pksu_pkg::CODE_W-1:0]       hit_code;

	assign hit_code = pksu_pkg::low_line_code(keys);
	assign code     = ready_q ? latched_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= pksu_pkg::PHASE_IDLE;
			cand_q    <= '0;
			latched_q <= '0;
			ready_q   <= 1'b0;
		end else begin
			phase_q   <= phase_nxt;
			cand_q    <= cand_nxt;
			latched_q <= latched_nxt;
			ready_q   <= ready_nxt;
		end
	end

	always_comb begin
		phase_nxt   = phase_q;
		cand_nxt    = cand_q;
		latched_nxt = latched_q;
		ready_nxt   = ready_q;
		if (ctl.read) begin
			ready_nxt = 1'b0;
		end
		if (ctl.sample) begin
			case (phase_q)
				pksu_pkg::PHASE_CONFIRM: begin
					if (keys == cand_q) begin
						if (hit_code != '0) begin
							latched_nxt = hit_code;
							ready_nxt   = 1'b1;
						end
						phase_nxt = pksu_pkg::PHASE_HELD;
					end else if (keys != idle_pattern) begin
						cand_nxt = keys;
					end else begin
						phase_nxt = pksu_pkg::PHASE_IDLE;
					end
				end
				pksu_pkg::PHASE_HELD: begin
					// any change ends the hold, new press counts from next sample
					if (keys != cand_q) begin
						phase_nxt = pksu_pkg::PHASE_IDLE;
					end
				end
				default: begin
					phase_nxt = pksu_pkg::PHASE_IDLE;
					if (keys != idle_pattern) begin
						cand_nxt  = keys;
						phase_nxt = pksu_pkg::PHASE_CONFIRM;
					end
				end
			endcase
		end
	end

endmodule

// ===== hdl/pksu_enc.sv =====
// one encoder delta accumulator with wrap correction and saturation
module pksu_enc (
	input  logic                                clk,
	input  logic                                arst_n,
	input  pksu_pkg::enc_ctl_t                  ctl,
	input  logic [pksu_pkg::POS_W-1:0]          pos,
	input  logic [pksu_pkg::POS_W-1:0]          wrap_high,
	input  logic [pksu_pkg::POS_W-1:0]          wrap_low,
	output logic signed [pksu_pkg::DELTA_W-1:0] sum
);

	localparam int STEP_W = pksu_pkg::POS_W + 2;
	localparam int ACC_W  = pksu_pkg::DELTA_W + 1;

	logic [pksu_pkg::POS_W-1:0]          last_q;
	logic                                primed_q;
	logic signed [pksu_pkg::DELTA_W-1:0] sum_q;
	logic signed [STEP_W-1:0]            raw_step, step;
	logic signed [ACC_W-1:0]             acc, sat;

	assign raw_step = $signed({2'b00, last_q}) - $signed({2'b00, pos});

	always_comb begin
		step = raw_step;
		if (pos > wrap_high && last_q < wrap_low) begin
			step = raw_step + STEP_W'(256);
		end else if (last_q > wrap_high && pos < wrap_low) begin
			step = raw_step - STEP_W'(256);
		end
		acc = $signed({sum_q[pksu_pkg::DELTA_W-1], sum_q})
			+ $signed({{(ACC_W-STEP_W){step[STEP_W-1]}}, step});
		sat = acc;
		if (acc > $signed(ACC_W'(pksu_pkg::SUM_LIMIT))) begin
			sat = ACC_W'(pksu_pkg::SUM_LIMIT);
		end else if (acc < -$signed(ACC_W'(pksu_pkg::SUM_LIMIT))) begin
			sat = -$signed(ACC_W'(pksu_pkg::SUM_LIMIT));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q   <= '0;
			primed_q <= 1'b0;
			sum_q    <= '0;
		end else begin
			if (ctl.clear) begin
				sum_q <= '0;
			end else if (ctl.tick && primed_q) begin
				sum_q <= sat[pksu_pkg::DELTA_W-1:0];
			end
			if (ctl.tick) begin
				last_q   <= pos;
				primed_q <= 1'b1;
			end
		end
	end

	assign sum = sum_q;

endmodule

// ===== hdl/panel_key_and_encoder_scanner_unit.sv =====
// top level of the front-panel key and encoder scanner
// an accepted item passes through the stage 1 register and then the result register
// throughput: one item per cycle, input stalls only while stage 1 and the result
// register are both full and m_tready is low
// reset: arst_n clears control, key phase, sums and positions; registers return to defaults
// first sample tick after reset captures the encoder positions and adds no delta
module panel_key_and_encoder_scanner_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration write port
	input  logic                               cfg_we,
	input  logic [pksu_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [pksu_pkg::CFG_W-1:0]         cfg_data,
	// request stream
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [31:0]                        s_tdata,  // panel_keys[15:0], encoder_a[23:16], encoder_b[31:24]
	input  logic [pksu_pkg::REQ_W-1:0]         s_tuser,  // req_type[1:0]
	// result stream
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [23:0]                        m_tdata   // key_code[4:0], delta_value[20:5], zero pad
);

	// configuration registers
	logic [pksu_pkg::KEY_W-1:0] idle_pattern_q;
	logic [pksu_pkg::POS_W-1:0] wrap_high_q;
	logic [pksu_pkg::POS_W-1:0] wrap_low_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_pattern_q <= pksu_pkg::IDLE_PATTERN_RST;
			wrap_high_q    <= pksu_pkg::WRAP_HIGH_RST;
			wrap_low_q     <= pksu_pkg::WRAP_LOW_RST;
		end else if (cfg_we) begin
			case (pksu_pkg::cfg_reg_t'(cfg_index))
				pksu_pkg::CFG_IDLE_PATTERN: idle_pattern_q <= cfg_data[pksu_pkg::KEY_W-1:0];
				pksu_pkg::CFG_WRAP_HIGH:    wrap_high_q    <= cfg_data[pksu_pkg::POS_W-1:0];
				pksu_pkg::CFG_WRAP_LOW:     wrap_low_q     <= cfg_data[pksu_pkg::POS_W-1:0];
				default: ; // unused index, write dropped
			endcase
		end
	end

	// input register stage
	logic                        valid_s1;
	pksu_pkg::req_t              req_s1;
	logic [pksu_pkg::KEY_W-1:0]  keys_s1;
	logic [pksu_pkg::POS_W-1:0]  pos_a_s1;
	logic [pksu_pkg::POS_W-1:0]  pos_b_s1;

	// result register
	logic                        out_valid_q;
	logic [23:0]                 out_data_q;

	logic advance;  // result register can take the item held in stage 1
	logic fire;     // stage 1 item is processed this cycle, state updates

	assign advance  = !out_valid_q || m_tready;
	assign fire     = valid_s1 && advance;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			req_s1   <= pksu_pkg::req_t'(s_tuser);
			keys_s1  <= s_tdata[15:0];
			pos_a_s1 <= s_tdata[23:16];
			pos_b_s1 <= s_tdata[31:24];
		end
	end

	// request decode, gated by the processing strobe
	pksu_pkg::key_ctl_t key_ctl;
	pksu_pkg::enc_ctl_t enc_a_ctl, enc_b_ctl;

	always_comb begin
		key_ctl.sample  = fire && (req_s1 == pksu_pkg::REQ_TICK);
		key_ctl.read    = fire && (req_s1 == pksu_pkg::REQ_READ_KEY);
		enc_a_ctl.tick  = key_ctl.sample;
		enc_a_ctl.clear = fire && (req_s1 == pksu_pkg::REQ_READ_A);
		enc_b_ctl.tick  = key_ctl.sample;
		enc_b_ctl.clear = fire && (req_s1 == pksu_pkg::REQ_READ_B);
	end

	logic [pksu_pkg::CODE_W-1:0]          key_code;
	logic signed [pksu_pkg::DELTA_W-1:0]  sum_a, sum_b;

	pksu_key u_key (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (key_ctl),
		.keys         (keys_s1),
		.idle_pattern (idle_pattern_q),
		.code         (key_code)
	);

	pksu_enc u_enc_a (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (enc_a_ctl),
		.pos       (pos_a_s1),
		.wrap_high (wrap_high_q),
		.wrap_low  (wrap_low_q),
		.sum       (sum_a)
	);

	pksu_enc u_enc_b (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (enc_b_ctl),
		.pos       (pos_b_s1),
		.wrap_high (wrap_high_q),
		.wrap_low  (wrap_low_q),
		.sum       (sum_b)
	);

	// result select: read values are taken before the clear lands
	logic [pksu_pkg::CODE_W-1:0]  res_code;
	logic [pksu_pkg::DELTA_W-1:0] res_delta;

	always_comb begin
		res_code  = '0;
		res_delta = '0;
		case (req_s1)
			pksu_pkg::REQ_READ_KEY: res_code  = key_code;
			pksu_pkg::REQ_READ_A:   res_delta = sum_a;
			pksu_pkg::REQ_READ_B:   res_delta = sum_b;
			default: ; // sample tick returns zeros
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_data_q <= {3'b000, res_delta, res_code};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// a result never carries both a key code and a delta
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_data_q[4:0] == '0 || out_data_q[20:5] == '0))
		else $error("key code and delta both nonzero");

	// saturation keeps deltas off the most negative value
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_data_q[20:5] != 16'h8000))
		else $error("delta outside saturation range");

	// key code stays within the scanned lines
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_data_q[4:0] <= pksu_pkg::CODE_W'(pksu_pkg::SCAN_LINES)))
		else $error("key code out of range");

	// a stalled stage 1 item is kept until it moves on
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> valid_s1)
		else $error("stage 1 item lost under stall");

endmodule
